// ===== src/line_segment_intersection_unit_defines.svh =====
// Assertion helpers for the line segment intersection unit.
// They expect signals named clk and rst_n in the including scope.
`ifndef LINE_SEGMENT_INTERSECTION_UNIT_DEFINES_SVH
`define LINE_SEGMENT_INTERSECTION_UNIT_DEFINES_SVH

// General concurrent property, sampled on clk and off while in reset.
`define LSI_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lsi: property failed");

// Overlapping implication form.
`define LSI_ASSERT_IMPL(lbl, ante, cons) `LSI_ASSERT(lbl, (ante) |-> (cons))

`endif

// ===== src/lsi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lsi_pkg;

    // Coordinate width and the exact widths that follow from it.
    localparam int COORD_WIDTH = 16;
    localparam int DW          = COORD_WIDTH + 1;       // coordinate difference
    localparam int PW          = 2 * DW;                // one difference product
    localparam int DENW        = PW + 1;                // cross product
    localparam int NUMW        = DW + DENW + 1;         // scaled crossing numerator
    localparam int QW          = NUMW + 1;              // signed quotient
    localparam int OUT_WIDTH   = 32;

    localparam logic [1:0] STAT_INSIDE   = 2'd0;
    localparam logic [1:0] STAT_OUTSIDE  = 2'd1;
    localparam logic [1:0] STAT_PARALLEL = 2'd2;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t a_start_x;
        coord_t a_start_y;
        coord_t a_end_x;
        coord_t a_end_y;
        coord_t b_start_x;
        coord_t b_start_y;
        coord_t b_end_x;
        coord_t b_end_y;
    } in_t;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] cross_x;
        logic signed [OUT_WIDTH-1:0] cross_y;
        logic [1:0]                  status;
        logic                        saturated;
    } out_t;

    // Facts about one transaction that ride alongside the divider.
    typedef struct packed {
        in_t  seg;
        logic parallel;
        logic neg_x;
        logic neg_y;
    } side_t;

    // One divider stage: partial remainders, numerator/quotient shifters.
    typedef struct packed {
        logic                valid;
        logic [DENW-1:0]     rem_x;
        logic [DENW-1:0]     rem_y;
        logic [NUMW-1:0]     nq_x;
        logic [NUMW-1:0]     nq_y;
        logic [DENW-1:0]     dvs;
        side_t               side;
    } div_t;

endpackage

`default_nettype wire

// ===== src/line_segment_intersection_unit.sv =====
// A transaction taken at a clock edge passes through these registered stages before its result strobe:
// six arithmetic stages, one divider stage per quotient bit (53), one output stage.
// Throughput: one transaction per cycle; busy stays low, the pipeline never stalls.
// Reset clears only the valid bits; no result strobe follows reset without a start.
`timescale 1ns / 1ps
`default_nettype none

`include "line_segment_intersection_unit_defines.svh"

module line_segment_intersection_unit import lsi_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire in_t  req,
    output logic      done,
    output out_t      res
);

    div_t front_out;
    div_t div_out;

    // The pipeline always has room, so a transaction is taken on every start.
    assign busy = 1'b0;

    lsi_front u_front (
        .clk  (clk),
        .rst_n(rst_n),
        .take (start & ~busy),
        .req  (req),
        .dout (front_out)
    );

    lsi_divider u_divider (
        .clk  (clk),
        .rst_n(rst_n),
        .din  (front_out),
        .dout (div_out)
    );

    lsi_back u_back (
        .clk  (clk),
        .rst_n(rst_n),
        .din  (div_out),
        .done (done),
        .res  (res)
    );

    // A parallel result carries no crossing and no saturation.
    `LSI_ASSERT_IMPL(a_parallel_zero, done && res.status == STAT_PARALLEL,
        res.cross_x == 0 && res.cross_y == 0 && !res.saturated)
    // A clipped crossing never counts as inside.
    `LSI_ASSERT_IMPL(a_sat_outside, done && res.saturated, res.status == STAT_OUTSIDE)
    // Only the three defined status codes appear.
    `LSI_ASSERT_IMPL(a_status_code, done, res.status == STAT_INSIDE
        || res.status == STAT_OUTSIDE || res.status == STAT_PARALLEL)

endmodule

`default_nettype wire

// ===== src/lsi_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lsi_front import lsi_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic take,
    input  wire in_t  req,
    output div_t      dout
);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    // Stage one: differences.
    logic signed [DW-1:0] dax_reg, day_reg, dbx_reg, dby_reg, ex_reg, ey_reg;
    in_t                  seg1_reg;

    // Stage two: difference products.
    logic signed [PW-1:0] pad_reg, pbd_reg, pen_reg, pfn_reg;
    logic signed [DW-1:0] dax2_reg, day2_reg;
    in_t                  seg2_reg;

    // Stage three: cross products.
    logic signed [DENW-1:0] den3_reg, num3_reg;
    logic signed [DW-1:0]   dax3_reg, day3_reg;
    in_t                    seg3_reg;

    // Stage four: scaling products.
    logic signed [COORD_WIDTH+DENW-1:0] mx0_reg, my0_reg;
    logic signed [DW+DENW-1:0]          mdx_reg, mdy_reg;
    logic signed [DENW-1:0]             den4_reg;
    in_t                                seg4_reg;

    // Stage five: numerators.
    logic signed [NUMW-1:0] nx_reg, ny_reg;
    logic signed [DENW-1:0] den5_reg;
    in_t                    seg5_reg;

    // Stage six: magnitudes and signs for the divider.
    div_t d6_reg;

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= take;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // Data path registers.
    always_ff @(posedge clk)
    begin
        dax_reg  <= DW'(req.a_end_x) - DW'(req.a_start_x);
        day_reg  <= DW'(req.a_end_y) - DW'(req.a_start_y);
        dbx_reg  <= DW'(req.b_end_x) - DW'(req.b_start_x);
        dby_reg  <= DW'(req.b_end_y) - DW'(req.b_start_y);
        ex_reg   <= DW'(req.b_start_x) - DW'(req.a_start_x);
        ey_reg   <= DW'(req.b_start_y) - DW'(req.a_start_y);
        seg1_reg <= req;

        pad_reg  <= PW'(dax_reg) * PW'(dby_reg);
        pbd_reg  <= PW'(day_reg) * PW'(dbx_reg);
        pen_reg  <= PW'(ex_reg) * PW'(dby_reg);
        pfn_reg  <= PW'(ey_reg) * PW'(dbx_reg);
        dax2_reg <= dax_reg;
        day2_reg <= day_reg;
        seg2_reg <= seg1_reg;

        den3_reg <= DENW'(pad_reg) - DENW'(pbd_reg);
        num3_reg <= DENW'(pen_reg) - DENW'(pfn_reg);
        dax3_reg <= dax2_reg;
        day3_reg <= day2_reg;
        seg3_reg <= seg2_reg;

        mx0_reg  <= (COORD_WIDTH+DENW)'(seg3_reg.a_start_x) * (COORD_WIDTH+DENW)'(den3_reg);
        my0_reg  <= (COORD_WIDTH+DENW)'(seg3_reg.a_start_y) * (COORD_WIDTH+DENW)'(den3_reg);
        mdx_reg  <= (DW+DENW)'(dax3_reg) * (DW+DENW)'(num3_reg);
        mdy_reg  <= (DW+DENW)'(day3_reg) * (DW+DENW)'(num3_reg);
        den4_reg <= den3_reg;
        seg4_reg <= seg3_reg;

        nx_reg   <= NUMW'(mx0_reg) + NUMW'(mdx_reg);
        ny_reg   <= NUMW'(my0_reg) + NUMW'(mdy_reg);
        den5_reg <= den4_reg;
        seg5_reg <= seg4_reg;

        d6_reg.valid         <= 1'b0;
        d6_reg.rem_x         <= '0;
        d6_reg.rem_y         <= '0;
        d6_reg.nq_x          <= nx_reg[NUMW-1] ? NUMW'(-nx_reg) : NUMW'(nx_reg);
        d6_reg.nq_y          <= ny_reg[NUMW-1] ? NUMW'(-ny_reg) : NUMW'(ny_reg);
        d6_reg.dvs           <= den5_reg[DENW-1] ? DENW'(-den5_reg) : DENW'(den5_reg);
        d6_reg.side.seg      <= seg5_reg;
        d6_reg.side.parallel <= (den5_reg == '0);
        d6_reg.side.neg_x    <= nx_reg[NUMW-1] ^ den5_reg[DENW-1];
        d6_reg.side.neg_y    <= ny_reg[NUMW-1] ^ den5_reg[DENW-1];
    end

    always_comb
    begin
        dout       = d6_reg;
        dout.valid = v6_reg;
    end

endmodule

`default_nettype wire

// ===== src/lsi_div_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lsi_div_step import lsi_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire div_t din,
    output div_t      dout
);

    logic [DENW:0]   tx, ty, dext;
    logic            gex, gey;
    logic            valid_reg;
    div_t            data_reg;
    div_t            data_next;

    // One restoring step for each coordinate against the shared divisor.
    always_comb
    begin
        dext = {1'b0, din.dvs};
        tx   = {din.rem_x, din.nq_x[NUMW-1]};
        ty   = {din.rem_y, din.nq_y[NUMW-1]};
        gex  = (tx >= dext);
        gey  = (ty >= dext);

        data_next       = din;
        data_next.rem_x = gex ? DENW'(tx - dext) : tx[DENW-1:0];
        data_next.rem_y = gey ? DENW'(ty - dext) : ty[DENW-1:0];
        data_next.nq_x  = {din.nq_x[NUMW-2:0], gex};
        data_next.nq_y  = {din.nq_y[NUMW-2:0], gey};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= din.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        dout       = data_reg;
        dout.valid = valid_reg;
    end

endmodule

`default_nettype wire

// ===== src/lsi_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lsi_divider import lsi_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire div_t din,
    output div_t      dout
);

    div_t chain [0:NUMW];

    assign chain[0] = din;

    // One registered stage for each quotient bit, most significant first.
    for (genvar i = 0; i < NUMW; i++)
    begin : g_step
        lsi_div_step u_step (
            .clk  (clk),
            .rst_n(rst_n),
            .din  (chain[i]),
            .dout (chain[i+1])
        );
    end

    assign dout = chain[NUMW];

endmodule

`default_nettype wire

// ===== src/lsi_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lsi_back import lsi_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire div_t din,
    output logic      done,
    output out_t      res
);

    localparam logic signed [QW-1:0] SAT_MAX = QW'({1'b0, {(OUT_WIDTH-1){1'b1}}});
    localparam logic signed [QW-1:0] SAT_MIN = QW'(signed'({1'b1, {(OUT_WIDTH-1){1'b0}}}));

    logic signed [QW-1:0] qx, qy;
    logic                 hi_x, lo_x, hi_y, lo_y, in_box;
    logic                 done_reg;
    out_t                 res_reg, res_next;

    // Closed span test of a quotient against two coordinates.
    function automatic logic in_span(logic signed [QW-1:0] v, coord_t p, coord_t q);
        logic signed [QW-1:0] lo, hi;
        lo = (p < q) ? QW'(p) : QW'(q);
        hi = (p < q) ? QW'(q) : QW'(p);
        return (v >= lo) && (v <= hi);
    endfunction

    // Sign fix, saturation and the box test.
    always_comb
    begin
        qx = din.side.neg_x ? -QW'({1'b0, din.nq_x}) : QW'({1'b0, din.nq_x});
        qy = din.side.neg_y ? -QW'({1'b0, din.nq_y}) : QW'({1'b0, din.nq_y});
        hi_x = (qx > SAT_MAX);
        lo_x = (qx < SAT_MIN);
        hi_y = (qy > SAT_MAX);
        lo_y = (qy < SAT_MIN);
        in_box = in_span(qx, din.side.seg.a_start_x, din.side.seg.a_end_x)
              && in_span(qy, din.side.seg.a_start_y, din.side.seg.a_end_y)
              && in_span(qx, din.side.seg.b_start_x, din.side.seg.b_end_x)
              && in_span(qy, din.side.seg.b_start_y, din.side.seg.b_end_y);

        if (din.side.parallel)
        begin
            res_next.cross_x   = '0;
            res_next.cross_y   = '0;
            res_next.status    = STAT_PARALLEL;
            res_next.saturated = 1'b0;
        end
        else
        begin
            res_next.cross_x   = hi_x ? SAT_MAX[OUT_WIDTH-1:0]
                               : (lo_x ? SAT_MIN[OUT_WIDTH-1:0] : qx[OUT_WIDTH-1:0]);
            res_next.cross_y   = hi_y ? SAT_MAX[OUT_WIDTH-1:0]
                               : (lo_y ? SAT_MIN[OUT_WIDTH-1:0] : qy[OUT_WIDTH-1:0]);
            res_next.status    = in_box ? STAT_INSIDE : STAT_OUTSIDE;
            res_next.saturated = hi_x | lo_x | hi_y | lo_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= din.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire

// ===== tb/lsi_checker.sv =====
`timescale 1ns / 1ps

module lsi_checker import lsi_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic busy,
    input  wire in_t  req,
    input  wire logic done,
    input  wire out_t res,
    output int        fail_count,
    output int        pending,
    output int        checked_count,
    output int        inside_count,
    output int        parallel_count,
    output int        clipped_count
);

    out_t crossing_q[$];

    // Exact crossing of the two lines, with box test and clipping to 32 bits.
    function automatic out_t crossing_of(in_t s);
        logic signed [127:0] x0, y0, x1, y1, x2, y2, x3, y3;
        logic signed [127:0] dax, day, dbx, dby, den, num, qx, qy;
        logic signed [127:0] lo, hi;
        logic ok;
        out_t r;
        x0 = s.a_start_x; y0 = s.a_start_y; x1 = s.a_end_x; y1 = s.a_end_y;
        x2 = s.b_start_x; y2 = s.b_start_y; x3 = s.b_end_x; y3 = s.b_end_y;
        dax = x1 - x0; day = y1 - y0; dbx = x3 - x2; dby = y3 - y2;
        den = dax * dby - day * dbx;
        r = '0;
        if (den == 0)
        begin
            r.status = STAT_PARALLEL;
            return r;
        end
        num = (x2 - x0) * dby - (y2 - y0) * dbx;
        qx = (x0 * den + dax * num) / den;
        qy = (y0 * den + day * num) / den;
        // Box test on the truncated, unclipped values, bounds included.
        ok = 1'b1;
        lo = (x0 < x1) ? x0 : x1; hi = (x0 < x1) ? x1 : x0;
        if (qx < lo || qx > hi) ok = 1'b0;
        lo = (y0 < y1) ? y0 : y1; hi = (y0 < y1) ? y1 : y0;
        if (qy < lo || qy > hi) ok = 1'b0;
        lo = (x2 < x3) ? x2 : x3; hi = (x2 < x3) ? x3 : x2;
        if (qx < lo || qx > hi) ok = 1'b0;
        lo = (y2 < y3) ? y2 : y3; hi = (y2 < y3) ? y3 : y2;
        if (qy < lo || qy > hi) ok = 1'b0;
        r.status = ok ? STAT_INSIDE : STAT_OUTSIDE;
        // Clip each coordinate to the signed 32-bit range.
        if (qx < -128'sd2147483648)
        begin
            r.cross_x = 32'h8000_0000; r.saturated = 1'b1;
        end
        else if (qx > 128'sd2147483647)
        begin
            r.cross_x = 32'h7FFF_FFFF; r.saturated = 1'b1;
        end
        else
            r.cross_x = qx[31:0];
        if (qy < -128'sd2147483648)
        begin
            r.cross_y = 32'h8000_0000; r.saturated = 1'b1;
        end
        else if (qy > 128'sd2147483647)
        begin
            r.cross_y = 32'h7FFF_FFFF; r.saturated = 1'b1;
        end
        else
            r.cross_y = qy[31:0];
        return r;
    endfunction

    assign pending = crossing_q.size();

    // Predict on each accepted transaction and compare each result strobe.
    always @(posedge clk or negedge rst_n)
    begin
        out_t e;
        if (!rst_n)
        begin
            fail_count     <= 0;
            checked_count  <= 0;
            inside_count   <= 0;
            parallel_count <= 0;
            clipped_count  <= 0;
        end
        else
        begin
            if (done)
            begin
                if (crossing_q.size() == 0)
                begin
                    $error("result with no transaction outstanding");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = crossing_q.pop_front();
                    checked_count <= checked_count + 1;
                    if (e.status == STAT_INSIDE) inside_count <= inside_count + 1;
                    if (e.status == STAT_PARALLEL) parallel_count <= parallel_count + 1;
                    if (e.saturated) clipped_count <= clipped_count + 1;
                    if (res.cross_x !== e.cross_x || res.cross_y !== e.cross_y ||
                        res.status !== e.status || res.saturated !== e.saturated)
                        fail_count <= fail_count + 1;
                    if (res.cross_x !== e.cross_x)
                        $error("cross_x expected %0d got %0d", e.cross_x, res.cross_x);
                    if (res.cross_y !== e.cross_y)
                        $error("cross_y expected %0d got %0d", e.cross_y, res.cross_y);
                    if (res.status !== e.status)
                        $error("status expected %0d got %0d", e.status, res.status);
                    if (res.saturated !== e.saturated)
                        $error("saturated expected %0d got %0d", e.saturated, res.saturated);
                end
            end
            if (start && !busy)
                crossing_q.push_back(crossing_of(req));
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import lsi_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int STALL_LIMIT  = 5000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    in_t  req;
    logic done;
    out_t res;
    int   fail_count, pending, checked_count, inside_count, parallel_count, clipped_count;
    int   sent_count;
    int   quiet_cycles;
    bit   no_gaps;

    line_segment_intersection_unit DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req(req), .done(done), .res(res)
    );

    lsi_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .res(res), .fail_count(fail_count), .pending(pending),
        .checked_count(checked_count), .inside_count(inside_count),
        .parallel_count(parallel_count), .clipped_count(clipped_count)
    );

    // 100 MHz clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: ends the run after a long stretch with no transaction either way.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Offer one pair of segments and hold it until it is taken, with random idle gaps.
    task automatic send_pair(input in_t s);
        while (!no_gaps && $urandom_range(99) < 21)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req   <= s;
        do
            @(posedge clk);
        while (busy);
        sent_count++;
    endtask

    function automatic in_t make_pair(int x0, int y0, int x1, int y1,
                                      int x2, int y2, int x3, int y3);
        in_t s;
        s.a_start_x = coord_t'(x0); s.a_start_y = coord_t'(y0);
        s.a_end_x   = coord_t'(x1); s.a_end_y   = coord_t'(y1);
        s.b_start_x = coord_t'(x2); s.b_start_y = coord_t'(y2);
        s.b_end_x   = coord_t'(x3); s.b_end_y   = coord_t'(y3);
        return s;
    endfunction

    function automatic int pick(int span);
        return $urandom_range(2 * span) - span;
    endfunction

    initial
    begin
        in_t s;
        int  k, dx, dy, m;
        sent_count   = 0;
        no_gaps      = 0;
        start        = 1'b0;
        req          = '0;
        rst_n        = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases: plain crossings, bounds, parallel and degenerate
        // segments, extreme coordinates and crossings far out of range.
        send_pair(make_pair(0, 0, 160, 160, 0, 160, 160, 0));
        send_pair(make_pair(0, 0, 16, 16, 100, 0, 116, -16));
        send_pair(make_pair(0, 0, 32, 0, 32, -16, 32, 16));
        send_pair(make_pair(-7, 3, 9, -5, 2, 11, -3, -13));
        send_pair(make_pair(0, 0, 16, 16, 16, 0, 32, 16));
        send_pair(make_pair(5, 5, 5, 5, 0, 0, 16, 16));
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        send_pair(make_pair(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768));
        send_pair(make_pair(-32768, 0, 32767, 1, -32768, 1, 32766, 2));
        send_pair(make_pair(-32768, 1, 32767, 0, -32768, 0, 32766, -1));
        send_pair(make_pair(0, -32768, 1, 32767, 1, -32768, 2, 32766));
        send_pair(make_pair(-32768, -32768, 32767, -32767, 32767, 32767, -32768, 32766));
        send_pair(make_pair(-32768, 32767, -32768, -32768, 32767, 0, -32768, 0));
        send_pair(make_pair(-1, -1, 1, 1, 1, -1, -1, 1));
        send_pair(make_pair(-1, 0, 2, 1, 0, 2, 1, -1));
        send_pair(make_pair(32767, -32768, -32768, 32767, 0, 0, 1, 1));
        send_pair(make_pair(0, 0, 32767, 0, 0, 32767, 1, -32768));

        // Random part: small segments as the largest share, plus full-range,
        // parallel and nearly parallel pairs; one long stretch runs without gaps.
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            no_gaps = (k >= 700 && k < 1000);
            m = $urandom_range(99);
            if (m < 30)
                s = make_pair(pick(32768), pick(32768), pick(32768), pick(32768),
                              pick(32768), pick(32768), pick(32768), pick(32768));
            else if (m < 75)
                s = make_pair(pick(300), pick(300), pick(300), pick(300),
                              pick(300), pick(300), pick(300), pick(300));
            else if (m < 87)
            begin
                dx = pick(2000);
                dy = pick(2000);
                s = make_pair(pick(20000), pick(20000), 0, 0, pick(20000), pick(20000), 0, 0);
                s.a_end_x = coord_t'(s.a_start_x + dx);
                s.a_end_y = coord_t'(s.a_start_y + dy);
                s.b_end_x = coord_t'(s.b_start_x + (($urandom_range(1)) ? dx : -dx));
                s.b_end_y = coord_t'(s.b_start_y
                                     + ((s.b_end_x == s.b_start_x + dx) ? dy : -dy));
            end
            else
            begin
                s = make_pair(pick(32768), pick(32768), pick(32768), pick(32768),
                              0, 0, 0, 0);
                s.b_start_x = coord_t'(s.a_start_x + pick(3));
                s.b_start_y = coord_t'(s.a_start_y + pick(3) + 1);
                s.b_end_x   = coord_t'(s.a_end_x + pick(1));
                s.b_end_y   = coord_t'(s.a_end_y + pick(1));
            end
            send_pair(s);
        end
        start <= 1'b0;
        @(posedge clk);

        // Drain the pipeline, then allow for a stray strobe.
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        $display("Sent %0d segment pairs; checked %0d results.", sent_count, checked_count);
        $display("Crossings inside both boxes: %0d, parallel: %0d, clipped: %0d.",
                 inside_count, parallel_count, clipped_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
